FILE: hdl/panel_frame_key_decoder_top_defines.svh
// ----------------------------------------------------------------------------
// Panel frame key decoder assertion macros
// Shared helpers for the concurrent checks on the decoder's ports.
// ----------------------------------------------------------------------------
`ifndef PANEL_FRAME_KEY_DECODER_TOP_DEFINES_SVH
`define PANEL_FRAME_KEY_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define PFKD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PFKD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/pfkd_pkg.sv
// ----------------------------------------------------------------------------
// Panel frame key decoder package
// Frame type, result type, protocol constants and the fixed key map.
// ----------------------------------------------------------------------------
`default_nettype none

package pfkd_pkg;

  localparam logic [7:0] HDR_BYTE   = 8'h7F;
  localparam logic [7:0] TYPE_PANEL = 8'h01;
  localparam logic [7:0] SRC_CARD   = 8'h01;
  localparam logic [7:0] SRC_07     = 8'h07;
  localparam logic [7:0] SRC_0D     = 8'h0D;
  localparam logic [7:0] SRC_0E     = 8'h0E;
  localparam logic [7:0] SRC_0F     = 8'h0F;
  localparam logic [7:0] SRC_11     = 8'h11;
  localparam logic [7:0] SRC_12     = 8'h12;
  localparam logic [7:0] SRC_31     = 8'h31;
  localparam logic [7:0] CMD_REMOVE = 8'h02;
  localparam logic [7:0] CMD_KEY1   = 8'h03;
  localparam logic [7:0] CMD_KEY2   = 8'h05;
  localparam logic [7:0] CMD_KEY3   = 8'h07;

  localparam logic EVT_KEY  = 1'b0;
  localparam logic EVT_CARD = 1'b1;

  localparam int MAP_SIZE    = 16;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0] ftype;
    logic [7:0] src;
    logic [7:0] cmd;
  } frame_t;

  typedef struct packed {
    logic       kind;
    logic [4:0] code;
    logic       present;
  } result_t;

  typedef struct packed {
    logic [7:0] addr;
    logic [1:0] pkey;
    logic [4:0] code;
  } map_entry_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] code;
  } map_hit_t;

  localparam map_entry_t KEY_MAP [MAP_SIZE] = '{
    '{SRC_07, 2'd1, 5'd29}, '{SRC_07, 2'd2, 5'd5},
    '{SRC_0D, 2'd1, 5'd8},  '{SRC_0D, 2'd2, 5'd30}, '{SRC_0D, 2'd3, 5'd31},
    '{SRC_31, 2'd2, 5'd30}, '{SRC_31, 2'd3, 5'd31},
    '{SRC_0E, 2'd1, 5'd7},  '{SRC_0E, 2'd2, 5'd6},  '{SRC_0E, 2'd3, 5'd9},
    '{SRC_0F, 2'd1, 5'd10}, '{SRC_0F, 2'd2, 5'd6},  '{SRC_0F, 2'd3, 5'd7},
    '{SRC_11, 2'd1, 5'd29},
    '{SRC_12, 2'd1, 5'd11}, '{SRC_12, 2'd2, 5'd29}
  };

  // The scan runs from the last entry down so that the first match wins.
  function automatic map_hit_t key_lookup(input logic [7:0] src, input logic [1:0] pkey);
    map_hit_t res;
    res = '0;
    for (int i = MAP_SIZE - 1; i >= 0; i--) begin
      if (KEY_MAP[i].addr == src && KEY_MAP[i].pkey == pkey) begin
        res.hit  = 1'b1;
        res.code = KEY_MAP[i].code;
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/panel_frame_key_decoder_top.sv
// ----------------------------------------------------------------------------
// Panel frame key decoder
// Turns panel serial bytes into keycard and key press events.
// ----------------------------------------------------------------------------
//   channel | handshake            | payload
//   input   | in_valid / in_ready  | rx_byte
//   output  | out_valid / out_ready| event_kind, key_code, card_present
//
// One byte is taken every cycle while the two-entry frame queue has room.
// A result passes from the byte that closes its frame through a queue entry
// and then the result register before it shows on the output.
// The queue fills only while the output stalls, and then in_ready drops.
// Synchronous reset empties the window, the queue and the output register.
`default_nettype none

module panel_frame_key_decoder_top #(
  parameter int FRAME_LEN = 8
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            event_kind,
  output logic [4:0]      key_code,
  output logic            card_present
);
  import pfkd_pkg::*;

  logic    accept;
  logic    push;
  frame_t  push_frame;
  logic    full;
  logic    pop;
  logic    head_valid;
  frame_t  head_frame;
  result_t result;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  pfkd_front #(.FRAME_LEN(FRAME_LEN)) u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx_byte),
    .push    (push),
    .frame   (push_frame)
  );

  pfkd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_frame (push_frame),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_frame (head_frame)
  );

  pfkd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_frame (head_frame),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result     (result)
  );

  assign event_kind   = result.kind;
  assign key_code     = result.code;
  assign card_present = result.present;

endmodule

`default_nettype wire

FILE: hdl/pfkd_front.sv
// ----------------------------------------------------------------------------
// Panel frame key decoder front end
// Sliding byte window that forms frames and pushes them into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pfkd_front #(
  parameter int FRAME_LEN = 8
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire logic [7:0]      rx_byte,
  output logic                 push,
  output pfkd_pkg::frame_t     frame
);
  import pfkd_pkg::*;

  localparam int IDX_W = $clog2(FRAME_LEN);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(FRAME_LEN - 1);

  logic [7:0]       win      [FRAME_LEN];
  logic [7:0]       win_next [FRAME_LEN];
  logic [IDX_W-1:0] fill;
  logic             at_end;
  logic             is_frame;

  always_comb begin
    for (int i = 0; i < FRAME_LEN; i++) begin
      win_next[i] = win[i];
    end
    win_next[fill] = rx_byte;
  end

  assign at_end   = (fill == LAST);
  assign is_frame = at_end && (win_next[0] == HDR_BYTE);
  assign push     = accept && is_frame;
  assign frame    = '{ftype: win_next[1], src: win_next[2], cmd: win_next[3]};

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (accept) begin
      if (!at_end) begin
        fill <= fill + 1'b1;
      end else if (is_frame) begin
        fill <= '0;
      end
    end
  end

  // A full window without a header loses its oldest byte; the last slot is
  // rewritten by the next request.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (at_end && !is_frame) begin
        for (int i = 0; i < FRAME_LEN - 1; i++) begin
          win[i] <= win_next[i + 1];
        end
        win[FRAME_LEN-1] <= win_next[FRAME_LEN-1];
      end else begin
        for (int i = 0; i < FRAME_LEN; i++) begin
          win[i] <= win_next[i];
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/pfkd_queue.sv
// ----------------------------------------------------------------------------
// Panel frame key decoder frame queue
// Short FIFO between the window front end and the decode back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pfkd_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  pfkd_pkg::frame_t      push_frame,
  output logic                  full,
  input  wire logic             pop,
  output logic                  head_valid,
  output pfkd_pkg::frame_t      head_frame
);
  import pfkd_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  frame_t           entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_frame = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_frame;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/pfkd_back.sv
// ----------------------------------------------------------------------------
// Panel frame key decoder back end
// Decodes a queued frame into a keycard or key event and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module pfkd_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             head_valid,
  input  pfkd_pkg::frame_t      head_frame,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output pfkd_pkg::result_t     result
);
  import pfkd_pkg::*;

  logic     is_card;
  logic     known_src;
  logic [1:0] pkey;
  map_hit_t lookup;
  logic     hit;
  result_t  dec;

  always_comb begin
    is_card = (head_frame.ftype == TYPE_PANEL)
           && (head_frame.src == SRC_CARD || head_frame.src == SRC_31)
           && (head_frame.cmd == CMD_KEY1 || head_frame.cmd == CMD_REMOVE);
    known_src = head_frame.src == SRC_07 || head_frame.src == SRC_0D ||
                head_frame.src == SRC_0E || head_frame.src == SRC_0F ||
                head_frame.src == SRC_11 || head_frame.src == SRC_12 ||
                head_frame.src == SRC_31;
    priority if (head_frame.cmd == CMD_KEY1) begin
      pkey = 2'd1;
    end else if (head_frame.cmd == CMD_KEY2) begin
      pkey = 2'd2;
    end else if (head_frame.cmd == CMD_KEY3) begin
      pkey = 2'd3;
    end else begin
      pkey = 2'd0;
    end
    lookup = key_lookup(head_frame.src, pkey);
    if (is_card) begin
      hit = 1'b1;
      dec = '{kind: EVT_CARD, code: 5'd0, present: (head_frame.cmd == CMD_KEY1)};
    end else begin
      hit = (head_frame.ftype == TYPE_PANEL) && known_src && (pkey != 2'd0) && lookup.hit;
      dec = '{kind: EVT_KEY, code: lookup.code, present: 1'b0};
    end
  end

  // A frame leaves the queue whenever the result register is free or drains.
  assign pop = head_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop && hit) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && hit) begin
      result <= dec;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/pfkd_checker.sv
// ----------------------------------------------------------------------------
// Panel frame key decoder port checker
// Watches the decoder's ports for output hold and event field consistency.
// ----------------------------------------------------------------------------
`default_nettype none

`include "panel_frame_key_decoder_top_defines.svh"

module pfkd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [7:0] rx_byte,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       event_kind,
  input wire logic [4:0] key_code,
  input wire logic       card_present
);
  import pfkd_pkg::*;

  logic unused_in;
  assign unused_in = in_valid ^ in_ready ^ (^rx_byte);

  `PFKD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(key_code) && $stable(event_kind) && $stable(card_present), "stalled result changed")
  `PFKD_ASSERT_SAME(a_card_code, clk, rst, out_valid && event_kind == EVT_CARD, key_code == 5'd0, "keycard event with nonzero key code")
  `PFKD_ASSERT_SAME(a_key_present, clk, rst, out_valid && event_kind == EVT_KEY, !card_present, "key event with card flag set")
  `PFKD_ASSERT_SAME(a_key_code, clk, rst, out_valid && event_kind == EVT_KEY, key_code != 5'd0, "key event with zero key code")

endmodule

bind panel_frame_key_decoder_top pfkd_checker u_pfkd_checker (.*);

`default_nettype wire

FILE: tb/panel_frame_key_decoder_top_tb.sv
// ----------------------------------------------------------------------------
// Panel frame key decoder testbench
// Feeds panel bytes through the valid/ready input, mirrors the sliding window
// and frame decode in a local predictor, and checks every event that leaves
// the output channel against the oldest predicted event.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module panel_frame_key_decoder_top_tb;
  import pfkd_pkg::*;

  localparam int FRAME_LEN        = 8;
  localparam int IDLE_PCT         = 34;
  localparam int RANDOM_BYTES     = 270;
  localparam int MIN_EVENTS       = 40;
  localparam int MAX_RANDOM_BYTES = 4000;
  localparam int DRAIN_AT         = 60;
  localparam int HOLD_START       = 100;
  localparam int HOLD_CYCLES      = 400;
  localparam int CALM_FROM        = 170;
  localparam int CALM_TO          = 250;
  localparam int TAIL_CYCLES      = 20;
  localparam int CYCLE_LIMIT      = 400000;

  typedef enum logic [1:0] {
    ROW_PREDICTED,
    ROW_SILENT,
    ROW_EVENT
  } row_check_t;

  // Carried along with each byte request; set only on the byte that closes
  // a directed frame whose outcome is written into the table.
  typedef struct packed {
    logic    typed;
    logic    typed_hit;
    result_t typed_res;
  } byte_tag_t;

  typedef struct packed {
    logic [3:0] lead;
    logic [7:0] lead_val;
    logic [7:0] hdr;
    logic [7:0] ftype;
    logic [7:0] src;
    logic [7:0] cmd;
    logic [7:0] tail;
    row_check_t check;
    result_t    res;
  } frame_row_t;

  localparam byte_tag_t NO_TAG = '0;
  localparam result_t   NO_RES = '0;

  localparam frame_row_t DIRECTED [15] = '{
    '{4'd0, 8'h00, HDR_BYTE, TYPE_PANEL, SRC_CARD, CMD_KEY1, 8'h00, ROW_EVENT,
      '{EVT_CARD, 5'd0, 1'b1}},
    '{4'd0, 8'h00, HDR_BYTE, TYPE_PANEL, SRC_31, CMD_REMOVE, 8'hFF, ROW_EVENT,
      '{EVT_CARD, 5'd0, 1'b0}},
    // Source 0x31 with command 3 is a card insert, not a key press.
    '{4'd0, 8'h00, HDR_BYTE, TYPE_PANEL, SRC_31, CMD_KEY1, HDR_BYTE, ROW_EVENT,
      '{EVT_CARD, 5'd0, 1'b1}},
    '{4'd0, 8'h00, HDR_BYTE, TYPE_PANEL, SRC_07, CMD_KEY1, 8'h55, ROW_EVENT,
      '{EVT_KEY, 5'd29, 1'b0}},
    '{4'd0, 8'h00, HDR_BYTE, TYPE_PANEL, SRC_0D, CMD_KEY3, 8'hAA, ROW_EVENT,
      '{EVT_KEY, 5'd31, 1'b0}},
    // Leading junk makes the window slide before the header lands in front.
    '{4'd3, 8'hFF, HDR_BYTE, TYPE_PANEL, SRC_12, CMD_KEY2, 8'h01, ROW_EVENT,
      '{EVT_KEY, 5'd29, 1'b0}},
    '{4'd0, 8'h00, HDR_BYTE, TYPE_PANEL, SRC_0E, CMD_KEY2, 8'h80, ROW_PREDICTED, NO_RES},
    '{4'd0, 8'h00, HDR_BYTE, TYPE_PANEL, SRC_0F, CMD_KEY3, 8'h7E, ROW_PREDICTED, NO_RES},
    '{4'd0, 8'h00, HDR_BYTE, TYPE_PANEL, SRC_31, CMD_KEY3, 8'h12, ROW_PREDICTED, NO_RES},
    '{4'd0, 8'h00, HDR_BYTE, TYPE_PANEL, SRC_11, CMD_KEY2, 8'h33, ROW_SILENT, NO_RES},
    '{4'd0, 8'h00, HDR_BYTE, 8'h02, SRC_0E, CMD_KEY1, 8'h44, ROW_SILENT, NO_RES},
    '{4'd0, 8'h00, HDR_BYTE, TYPE_PANEL, 8'h55, CMD_KEY1, 8'h66, ROW_SILENT, NO_RES},
    '{4'd0, 8'h00, HDR_BYTE, TYPE_PANEL, SRC_CARD, CMD_KEY2, 8'h77, ROW_SILENT, NO_RES},
    '{4'd0, 8'h00, HDR_BYTE, TYPE_PANEL, SRC_0E, 8'h04, 8'h99, ROW_SILENT, NO_RES},
    '{4'd5, 8'h00, HDR_BYTE, TYPE_PANEL, SRC_0E, CMD_KEY1, 8'h00, ROW_PREDICTED, NO_RES}
  };

  localparam logic [7:0] SRC_LIST [8] = '{
    SRC_CARD, SRC_07, SRC_0D, SRC_0E, SRC_0F, SRC_11, SRC_12, SRC_31
  };
  localparam logic [7:0] CMD_LIST [4] = '{CMD_REMOVE, CMD_KEY1, CMD_KEY2, CMD_KEY3};

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       event_kind;
  logic [4:0] key_code;
  logic       card_present;
  byte_tag_t  cur_tag;

  // Predictor state: the byte window and how many bytes it holds.
  logic [7:0]  win [FRAME_LEN];
  int unsigned fill;

  result_t     event_q [$];
  logic        pred_hit;
  result_t     pred_res;
  result_t     oldest;
  int          errors = 0;
  int          events_predicted = 0;
  int          rand_sent = 0;
  bit          calm = 1'b0;
  bit          hold_rx = 1'b0;
  int unsigned cycle_count = 0;

  panel_frame_key_decoder_top #(
    .FRAME_LEN(FRAME_LEN)
  ) uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .event_kind  (event_kind),
    .key_code    (key_code),
    .card_present(card_present)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void frame_decode(input logic [7:0] ftype, input logic [7:0] src,
                                       input logic [7:0] cmd, output logic hit,
                                       output result_t res);
    logic [1:0] pkey;
    hit  = 1'b0;
    res  = '0;
    pkey = 2'd0;
    if (ftype != TYPE_PANEL) return;
    if ((src == SRC_CARD || src == SRC_31) && (cmd == CMD_KEY1 || cmd == CMD_REMOVE)) begin
      hit         = 1'b1;
      res.kind    = EVT_CARD;
      res.present = (cmd == CMD_KEY1);
      return;
    end
    unique case (cmd)
      CMD_KEY1: pkey = 2'd1;
      CMD_KEY2: pkey = 2'd2;
      CMD_KEY3: pkey = 2'd3;
      default:  pkey = 2'd0;
    endcase
    if (pkey == 2'd0) return;
    hit      = 1'b1;
    res.kind = EVT_KEY;
    // Unknown sources have no entry, so they fall through to the default.
    unique case ({src, pkey})
      {SRC_07, 2'd1}: res.code = 5'd29;
      {SRC_07, 2'd2}: res.code = 5'd5;
      {SRC_0D, 2'd1}: res.code = 5'd8;
      {SRC_0D, 2'd2}: res.code = 5'd30;
      {SRC_0D, 2'd3}: res.code = 5'd31;
      {SRC_31, 2'd2}: res.code = 5'd30;
      {SRC_31, 2'd3}: res.code = 5'd31;
      {SRC_0E, 2'd1}: res.code = 5'd7;
      {SRC_0E, 2'd2}: res.code = 5'd6;
      {SRC_0E, 2'd3}: res.code = 5'd9;
      {SRC_0F, 2'd1}: res.code = 5'd10;
      {SRC_0F, 2'd2}: res.code = 5'd6;
      {SRC_0F, 2'd3}: res.code = 5'd7;
      {SRC_11, 2'd1}: res.code = 5'd29;
      {SRC_12, 2'd1}: res.code = 5'd11;
      {SRC_12, 2'd2}: res.code = 5'd29;
      default: begin
        hit = 1'b0;
        res = '0;
      end
    endcase
  endfunction

  // Between bytes the window never holds more than FRAME_LEN-1 entries.
  task automatic window_take(input logic [7:0] b, output logic hit, output result_t res);
    hit = 1'b0;
    res = '0;
    win[fill] = b;
    fill++;
    if (fill >= FRAME_LEN) begin
      if (win[0] == HDR_BYTE) begin
        fill = 0;
        frame_decode(win[1], win[2], win[3], hit, res);
      end else begin
        for (int i = 1; i < FRAME_LEN; i++) win[i-1] = win[i];
        fill = FRAME_LEN - 1;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at %0t: %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  task automatic offer_byte(input logic [7:0] b, input byte_tag_t tag);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    cur_tag  <= tag;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // The prediction is queued before the output is checked, so a result in
  // the same cycle as its closing byte would still find its expectation.
  always @(posedge clk) begin
    if (rst) begin
      fill = 0;
      foreach (win[i]) win[i] = '0;
    end else begin
      if (in_valid && in_ready) begin
        window_take(rx_byte, pred_hit, pred_res);
        if (cur_tag.typed) begin
          pred_hit = cur_tag.typed_hit;
          pred_res = cur_tag.typed_res;
        end
        if (pred_hit) begin
          event_q.push_back(pred_res);
          events_predicted++;
        end
      end
      if (out_valid && out_ready) begin
        if (event_q.size() == 0) begin
          report_mismatch("result with nothing expected",
                          {event_kind, key_code, card_present}, -1);
        end else begin
          oldest = event_q.pop_front();
          if (event_kind !== oldest.kind)
            report_mismatch("event_kind", event_kind, oldest.kind);
          if (key_code !== oldest.code)
            report_mismatch("key_code", key_code, oldest.code);
          if (card_present !== oldest.present)
            report_mismatch("card_present", card_present, oldest.present);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || hold_rx) begin
      out_ready <= 1'b0;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Long output stall while the sender keeps going, so the frame queue
  // fills and the input request is held back.
  initial begin
    wait (rand_sent >= HOLD_START);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    frame_row_t row;
    byte_tag_t  tag;
    logic [7:0] burst [$];
    int         keep;
    bit         drained;

    drained   = 1'b0;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    rx_byte  <= '0;
    cur_tag  <= NO_TAG;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[r]) begin
      row = DIRECTED[r];
      for (int j = 0; j < row.lead; j++) offer_byte(row.lead_val, NO_TAG);
      offer_byte(row.hdr, NO_TAG);
      offer_byte(row.ftype, NO_TAG);
      offer_byte(row.src, NO_TAG);
      offer_byte(row.cmd, NO_TAG);
      for (int j = 4; j < FRAME_LEN; j++) begin
        tag = NO_TAG;
        if (j == FRAME_LEN - 1 && row.check != ROW_PREDICTED) begin
          tag.typed     = 1'b1;
          tag.typed_hit = (row.check == ROW_EVENT);
          tag.typed_res = row.res;
        end
        offer_byte(row.tail, tag);
      end
    end

    while ((rand_sent < RANDOM_BYTES || events_predicted < MIN_EVENTS) &&
           rand_sent < MAX_RANDOM_BYTES) begin
      if (rand_sent >= DRAIN_AT && !drained) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (event_q.size() != 0) @(posedge clk);
        drained = 1'b1;
      end
      calm <= (rand_sent >= CALM_FROM && rand_sent < CALM_TO);

      burst.delete();
      if ($urandom_range(99) < 80) begin
        // Mostly well-formed frames with random content; a few are cut short.
        burst.push_back(($urandom_range(99) < 90) ? HDR_BYTE : 8'($urandom_range(255)));
        burst.push_back(($urandom_range(99) < 85) ? TYPE_PANEL : 8'($urandom_range(255)));
        burst.push_back(($urandom_range(99) < 85) ? SRC_LIST[$urandom_range(7)]
                                                  : 8'($urandom_range(255)));
        burst.push_back(($urandom_range(99) < 85) ? CMD_LIST[$urandom_range(3)]
                                                  : 8'($urandom_range(255)));
        repeat (FRAME_LEN - 4) burst.push_back(8'($urandom_range(255)));
        if ($urandom_range(99) < 10) begin
          keep = $urandom_range(FRAME_LEN - 1, 1);
          while (burst.size() > keep) void'(burst.pop_back());
        end
      end else begin
        repeat ($urandom_range(6, 1)) burst.push_back(8'($urandom_range(255)));
      end

      foreach (burst[k]) begin
        offer_byte(burst[k], NO_TAG);
        rand_sent++;
      end
    end

    in_valid <= 1'b0;
    calm     <= 1'b0;
    @(posedge clk);
    while (event_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (event_q.size() != 0) report_mismatch("results never delivered", 0, event_q.size());

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
